@@ rtl/core/rhc_pkg.sv @@
// Shared constants for the RGB to HSV converter.
// Used by rhc_prep and rgb_to_hsv_converter; depends on nothing.
`timescale 1ns / 1ps

package rhc_pkg;

   // Width of the hue field on the result channel.
   localparam int HUE_OUT_BITS = 15;

   // One hue sector and one full turn, in degrees.
   localparam int SECTOR_DEGREES    = 60;
   localparam int FULL_TURN_DEGREES = 360;

endpackage

@@ rtl/core/rgb_to_hsv_converter.sv @@
// Top level of the RGB to HSV converter: front end, two pipelined dividers
// and the delay line for value, alpha and valid. Uses rhc_pkg, rhc_prep and
// rhc_divider.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_stall   red, green, blue, alpha
//   rsp_     out        rsp_valid/rsp_stall   hue, saturation, value, alpha
//
// A request passes two front-end stages and then DIV_STAGES divider stages,
// DIV_STAGES = max(9 + HUE_FRAC_BITS, CHANNEL_BITS); each divider works out one
// quotient bit per stage and only holds beyond its quotient width. One request
// can enter on every clock while req_stall is low. Reset clears only the valid
// bits. While a finished result waits on rsp_stall, every stage holds, empty ones
// included, and req_stall is raised for as long as the result waits.
`timescale 1ns / 1ps

module rgb_to_hsv_converter #(
   parameter int CHANNEL_BITS  = 8,
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [CHANNEL_BITS-1:0]          req_red_in,
   input  logic [CHANNEL_BITS-1:0]          req_green_in,
   input  logic [CHANNEL_BITS-1:0]          req_blue_in,
   input  logic [CHANNEL_BITS-1:0]          req_alpha_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rhc_pkg::HUE_OUT_BITS-1:0] rsp_hue_out,
   output logic [CHANNEL_BITS-1:0]          rsp_saturation_out,
   output logic [CHANNEL_BITS-1:0]          rsp_value_out,
   output logic [CHANNEL_BITS-1:0]          rsp_alpha_out
);

   // The hue quotient stays below 360 degrees in hue units.
   localparam int HueQuoBits = $clog2(rhc_pkg::FULL_TURN_DEGREES << HUE_FRAC_BITS);
   localparam int DivStages  = (HueQuoBits > CHANNEL_BITS) ? HueQuoBits : CHANNEL_BITS;
   localparam int HueWideBits =
      (HueQuoBits > rhc_pkg::HUE_OUT_BITS) ? HueQuoBits : rhc_pkg::HUE_OUT_BITS;

   logic                                 advance;
   logic                                 pre_valid;
   logic [CHANNEL_BITS-1:0]              pre_value;
   logic [CHANNEL_BITS-1:0]              pre_alpha;
   logic [2*CHANNEL_BITS-1:0]            pre_sat_num;
   logic [CHANNEL_BITS-1:0]              pre_sat_den;
   logic [CHANNEL_BITS+HueQuoBits-1:0]   pre_hue_num;
   logic [CHANNEL_BITS-1:0]              pre_hue_den;
   logic [CHANNEL_BITS-1:0]              sat_quo;
   logic [HueQuoBits-1:0]                hue_quo;
   logic [HueWideBits-1:0]               hue_wide;

   logic                    valid_ff [DivStages];
   logic [CHANNEL_BITS-1:0] value_ff [DivStages];
   logic [CHANNEL_BITS-1:0] alpha_ff [DivStages];

   // Every stage moves together unless a finished result is held off.
   assign advance   = !(valid_ff[DivStages-1] && rsp_stall);
   assign req_stall = !advance;

   rhc_prep #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .HUE_QUO_BITS  (HueQuoBits)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .up_valid   (req_valid),
      .up_red     (req_red_in),
      .up_green   (req_green_in),
      .up_blue    (req_blue_in),
      .up_alpha   (req_alpha_in),
      .dn_valid   (pre_valid),
      .dn_value   (pre_value),
      .dn_alpha   (pre_alpha),
      .dn_sat_num (pre_sat_num),
      .dn_sat_den (pre_sat_den),
      .dn_hue_num (pre_hue_num),
      .dn_hue_den (pre_hue_den)
   );

   // Saturation: spread times full scale over the largest channel.
   rhc_divider #(
      .DEN_BITS (CHANNEL_BITS),
      .QUO_BITS (CHANNEL_BITS),
      .STAGES   (DivStages)
   ) u_sat_div (
      .clock   (clock),
      .advance (advance),
      .num     (pre_sat_num),
      .den     (pre_sat_den),
      .quo     (sat_quo)
   );

   // Hue: sector position times one sector over the spread.
   rhc_divider #(
      .DEN_BITS (CHANNEL_BITS),
      .QUO_BITS (HueQuoBits),
      .STAGES   (DivStages)
   ) u_hue_div (
      .clock   (clock),
      .advance (advance),
      .num     (pre_hue_num),
      .den     (pre_hue_den),
      .quo     (hue_quo)
   );

   // Value, alpha and valid ride alongside the dividers.
   for (genvar s = 0; s < DivStages; s++) begin : g_delay
      logic                    valid_prev;
      logic [CHANNEL_BITS-1:0] value_prev;
      logic [CHANNEL_BITS-1:0] alpha_prev;

      if (s == 0) begin : g_first
         assign valid_prev = pre_valid;
         assign value_prev = pre_value;
         assign alpha_prev = pre_alpha;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign value_prev = value_ff[s-1];
         assign alpha_prev = alpha_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            value_ff[s] <= value_prev;
            alpha_ff[s] <= alpha_prev;
         end
      end
   end

   // The hue field keeps only its low bits when the quotient is wider.
   assign hue_wide           = HueWideBits'(hue_quo);
   assign rsp_hue_out        = hue_wide[rhc_pkg::HUE_OUT_BITS-1:0];
   assign rsp_saturation_out = sat_quo;
   assign rsp_value_out      = value_ff[DivStages-1];
   assign rsp_alpha_out      = alpha_ff[DivStages-1];
   assign rsp_valid          = valid_ff[DivStages-1];

endmodule

@@ rtl/core/rhc_prep.sv @@
// Front end of the RGB to HSV converter: max, min, spread and sector position,
// then the dividends and divisors for the two dividers. Uses rhc_pkg.
`timescale 1ns / 1ps

module rhc_prep #(
   parameter int CHANNEL_BITS  = 8,
   parameter int HUE_FRAC_BITS = 6,
   parameter int HUE_QUO_BITS  = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 up_valid,
   input  logic [CHANNEL_BITS-1:0]              up_red,
   input  logic [CHANNEL_BITS-1:0]              up_green,
   input  logic [CHANNEL_BITS-1:0]              up_blue,
   input  logic [CHANNEL_BITS-1:0]              up_alpha,
   output logic                                 dn_valid,
   output logic [CHANNEL_BITS-1:0]              dn_value,
   output logic [CHANNEL_BITS-1:0]              dn_alpha,
   output logic [2*CHANNEL_BITS-1:0]            dn_sat_num,
   output logic [CHANNEL_BITS-1:0]              dn_sat_den,
   output logic [CHANNEL_BITS+HUE_QUO_BITS-1:0] dn_hue_num,
   output logic [CHANNEL_BITS-1:0]              dn_hue_den
);

   // The sector position is below six times the spread.
   localparam int PosBits = CHANNEL_BITS + 3;
   localparam int HueNumBits = CHANNEL_BITS + HUE_QUO_BITS;
   localparam int SectorUnits = rhc_pkg::SECTOR_DEGREES << HUE_FRAC_BITS;

   logic [CHANNEL_BITS-1:0] max_rg;
   logic [CHANNEL_BITS-1:0] max_all;
   logic [CHANNEL_BITS-1:0] min_rg;
   logic [CHANNEL_BITS-1:0] min_all;
   logic [CHANNEL_BITS-1:0] spread;
   logic [PosBits-1:0]      pos;

   logic                    s1_valid_ff;
   logic [CHANNEL_BITS-1:0] s1_max_ff;
   logic [CHANNEL_BITS-1:0] s1_spread_ff;
   logic [PosBits-1:0]      s1_pos_ff;
   logic [CHANNEL_BITS-1:0] s1_alpha_ff;

   logic                                 s2_valid_ff;
   logic [CHANNEL_BITS-1:0]              s2_value_ff;
   logic [CHANNEL_BITS-1:0]              s2_alpha_ff;
   logic [2*CHANNEL_BITS-1:0]            s2_sat_num_ff;
   logic [CHANNEL_BITS-1:0]              s2_sat_den_ff;
   logic [HueNumBits-1:0]                s2_hue_num_ff;
   logic [CHANNEL_BITS-1:0]              s2_hue_den_ff;

   logic [2*CHANNEL_BITS-1:0]            sat_num_in;
   logic [CHANNEL_BITS-1:0]              sat_den_in;
   logic [HueNumBits-1:0]                hue_num_in;
   logic [CHANNEL_BITS-1:0]              hue_den_in;
   logic [HueNumBits-1:0]                pos_wide;

   // Stage one: the largest channel picks the sector, red first on ties.
   always_comb begin
      max_rg  = (up_red > up_green) ? up_red : up_green;
      max_all = (max_rg > up_blue) ? max_rg : up_blue;
      min_rg  = (up_red < up_green) ? up_red : up_green;
      min_all = (min_rg < up_blue) ? min_rg : up_blue;
      spread  = max_all - min_all;
      if (up_red == max_all) begin
         if (up_green >= up_blue) begin
            pos = PosBits'(up_green) - PosBits'(up_blue);
         end else begin
            pos = (PosBits'(spread) << 2) + (PosBits'(spread) << 1)
                  - (PosBits'(up_blue) - PosBits'(up_green));
         end
      end else if (up_green == max_all) begin
         pos = (PosBits'(spread) << 1) + PosBits'(up_blue) - PosBits'(up_red);
      end else begin
         pos = (PosBits'(spread) << 2) + PosBits'(up_red) - PosBits'(up_green);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_max_ff    <= max_all;
         s1_spread_ff <= spread;
         s1_pos_ff    <= pos;
         s1_alpha_ff  <= up_alpha;
      end
   end

   // Stage two: spread times full scale, and position times one sector in
   // hue units. A grey pixel gets a divisor of one so that both quotients
   // come out zero.
   always_comb begin
      sat_num_in = (2*CHANNEL_BITS)'(s1_spread_ff) << CHANNEL_BITS;
      sat_num_in = sat_num_in - (2*CHANNEL_BITS)'(s1_spread_ff);
      pos_wide   = HueNumBits'(s1_pos_ff);
      hue_num_in = pos_wide * HueNumBits'(SectorUnits);
      if (s1_spread_ff == '0) begin
         sat_den_in = CHANNEL_BITS'(1);
         hue_den_in = CHANNEL_BITS'(1);
      end else begin
         sat_den_in = s1_max_ff;
         hue_den_in = s1_spread_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_value_ff   <= s1_max_ff;
         s2_alpha_ff   <= s1_alpha_ff;
         s2_sat_num_ff <= sat_num_in;
         s2_sat_den_ff <= sat_den_in;
         s2_hue_num_ff <= hue_num_in;
         s2_hue_den_ff <= hue_den_in;
      end
   end

   assign dn_valid   = s2_valid_ff;
   assign dn_value   = s2_value_ff;
   assign dn_alpha   = s2_alpha_ff;
   assign dn_sat_num = s2_sat_num_ff;
   assign dn_sat_den = s2_sat_den_ff;
   assign dn_hue_num = s2_hue_num_ff;
   assign dn_hue_den = s2_hue_den_ff;

endmodule

@@ rtl/core/rhc_divider.sv @@
// Pipelined restoring divider for the RGB to HSV converter, one quotient bit
// per stage; early stages past the quotient width only hold. No package use.
`timescale 1ns / 1ps

module rhc_divider #(
   parameter int DEN_BITS = 8,
   parameter int QUO_BITS = 8,
   parameter int STAGES   = 8
) (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [DEN_BITS+QUO_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]          den,
   output logic [QUO_BITS-1:0]          quo
);

   // The dividend must be below den * 2**QUO_BITS.
   localparam int RemBits = DEN_BITS + QUO_BITS;

   logic [RemBits-1:0]  rem_ff [STAGES];
   logic [DEN_BITS-1:0] den_ff [STAGES];
   logic [QUO_BITS-1:0] quo_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int BitIdx = STAGES - 1 - s;

      logic [RemBits-1:0]  rem_prev;
      logic [DEN_BITS-1:0] den_prev;
      logic [QUO_BITS-1:0] quo_prev;
      logic [RemBits-1:0]  rem_in;
      logic [QUO_BITS-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      if (BitIdx < QUO_BITS) begin : g_sub
         logic [RemBits:0] diff;
         always_comb begin
            diff   = {1'b0, rem_prev} - ({1'b0, RemBits'(den_prev)} << BitIdx);
            quo_in = quo_prev;
            if (diff[RemBits]) begin
               rem_in = rem_prev;
            end else begin
               rem_in = diff[RemBits-1:0];
               quo_in[BitIdx] = 1'b1;
            end
         end
      end else begin : g_hold
         assign rem_in = rem_prev;
         assign quo_in = quo_prev;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[STAGES-1];

endmodule
